### hw/rtl/qpm_pkg.sv
package qpm_pkg;

    localparam int NLANE = 9;
    localparam int QBITS = 17;
    localparam int MAG_W = 32;
    localparam int LEN_W = 33;
    localparam int REM_W = 48;
    localparam int DEN_W = 34;
    localparam int CMP_W = DEN_W + QBITS;
    localparam int V_W   = QBITS + 1;

    localparam logic [LEN_W-1:0]     LEN_SQ_MIN = LEN_W'(16);
    localparam logic signed [15:0]   ONE_Q14    = 16'sd16384;
    localparam logic signed [V_W-1:0] ONE_V     = V_W'(16384);

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_pose;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } t_xform;

    // data that rides alongside the divider
    typedef struct packed {
        logic [NLANE-1:0]   neg;
        logic               short_q;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_side;

endpackage

### hw/rtl/qpm_stream_if.sv
interface qpm_pose_if;
    import qpm_pkg::*;
    logic  valid;
    logic  ready;
    t_pose data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qpm_xform_if;
    import qpm_pkg::*;
    logic   valid;
    logic   ready;
    t_xform data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/qpm_div.sv
module qpm_div
    import qpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [REM_W-1:0] i_num [NLANE],
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [QBITS-1:0] o_quot [NLANE],
    output t_side            o_side
);

    // one quotient bit per stage, msb first, restoring
    logic [REM_W-1:0] r_rem  [QBITS][NLANE];
    logic [QBITS-1:0] r_q    [QBITS][NLANE];
    logic [DEN_W-1:0] r_den  [QBITS];
    t_side            r_side [QBITS];
    logic [QBITS-1:0] r_vld;

    logic [REM_W-1:0] n_rem  [QBITS][NLANE];
    logic [QBITS-1:0] n_q    [QBITS][NLANE];

    // what each stage starts from
    logic [REM_W-1:0] s_rem  [QBITS][NLANE];
    logic [QBITS-1:0] s_q    [QBITS][NLANE];
    logic [DEN_W-1:0] s_den  [QBITS];
    t_side            s_side [QBITS];

    always_comb begin
        s_den[0]  = i_den;
        s_side[0] = i_side;
        for (int l = 0; l < NLANE; l++) begin
            s_rem[0][l] = i_num[l];
            s_q[0][l]   = '0;
        end
        for (int s = 1; s < QBITS; s++) begin
            s_rem[s]  = r_rem[s-1];
            s_q[s]    = r_q[s-1];
            s_den[s]  = r_den[s-1];
            s_side[s] = r_side[s-1];
        end
    end

    always_comb begin
        logic [REM_W-1:0] src_rem;
        logic [QBITS-1:0] src_q;
        logic [DEN_W-1:0] src_den;
        logic [CMP_W-1:0] cmp_den;
        logic [CMP_W-1:0] cmp_rem;
        for (int s = 0; s < QBITS; s++) begin
            for (int l = 0; l < NLANE; l++) begin
                src_rem = s_rem[s][l];
                src_q   = s_q[s][l];
                src_den = s_den[s];
                cmp_den = CMP_W'(src_den) << (QBITS - 1 - s);
                cmp_rem = CMP_W'(src_rem);
                if (cmp_rem >= cmp_den) begin
                    n_rem[s][l] = REM_W'(cmp_rem - cmp_den);
                    n_q[s][l]   = src_q | (QBITS'(1) << (QBITS - 1 - s));
                end else begin
                    n_rem[s][l] = src_rem;
                    n_q[s][l]   = src_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QBITS-2:0], i_vld};
        end
        if (i_en) begin
            for (int s = 0; s < QBITS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
                r_den[s]  <= s_den[s];
                r_side[s] <= s_side[s];
            end
        end
    end

    assign o_vld  = r_vld[QBITS-1];
    assign o_quot = r_q[QBITS-1];
    assign o_side = r_side[QBITS-1];

endmodule

### hw/rtl/quaternion_pose_to_matrix.sv
// pipeline: 3 front stages, 17 divider stages with one quotient bit each, 1 output stage
// throughput: one word per cycle; the whole pipe holds while the output word waits
// reset: synchronous active low, clears the valid bits only
module quaternion_pose_to_matrix
    import qpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    qpm_pose_if.sink    i_pose,
    qpm_xform_if.source o_xform
);

    logic en;

    // stage 1: products
    logic               r1_vld;
    logic signed [31:0] r1_xx, r1_yy, r1_zz, r1_ww;
    logic signed [31:0] r1_xy, r1_xz, r1_yz, r1_xw, r1_yw, r1_zw;
    logic signed [31:0] r1_px, r1_py, r1_pz;

    // stage 2: length and magnitudes
    logic               r2_vld;
    logic [LEN_W-1:0]   r2_len;
    logic [MAG_W-1:0]   r2_mag [NLANE];
    logic [NLANE-1:0]   r2_neg;
    logic signed [31:0] r2_px, r2_py, r2_pz;

    // stage 3: rounding numerator and doubled denominator
    logic               r3_vld;
    logic [REM_W-1:0]   r3_num [NLANE];
    logic [DEN_W-1:0]   r3_den;
    t_side              r3_side;

    logic               div_vld;
    logic [QBITS-1:0]   div_quot [NLANE];
    t_side              div_side;

    logic               r_out_vld;
    t_xform             r_out;

    logic [MAG_W-1:0]   n2_mag [NLANE];
    logic [NLANE-1:0]   n2_neg;
    logic signed [15:0] n_m [NLANE];

    assign en           = !r_out_vld || o_xform.ready;
    assign i_pose.ready = en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xx <= i_pose.data.quat_x * i_pose.data.quat_x;
            r1_yy <= i_pose.data.quat_y * i_pose.data.quat_y;
            r1_zz <= i_pose.data.quat_z * i_pose.data.quat_z;
            r1_ww <= i_pose.data.quat_w * i_pose.data.quat_w;
            r1_xy <= i_pose.data.quat_x * i_pose.data.quat_y;
            r1_xz <= i_pose.data.quat_x * i_pose.data.quat_z;
            r1_yz <= i_pose.data.quat_y * i_pose.data.quat_z;
            r1_xw <= i_pose.data.quat_x * i_pose.data.quat_w;
            r1_yw <= i_pose.data.quat_y * i_pose.data.quat_w;
            r1_zw <= i_pose.data.quat_z * i_pose.data.quat_w;
            r1_px <= i_pose.data.pos_x;
            r1_py <= i_pose.data.pos_y;
            r1_pz <= i_pose.data.pos_z;
        end
    end

    always_comb begin
        logic signed [LEN_W-1:0] d [NLANE];
        d[0] = LEN_W'(r1_yy) + LEN_W'(r1_zz);
        d[1] = LEN_W'(r1_xy) - LEN_W'(r1_zw);
        d[2] = LEN_W'(r1_xz) + LEN_W'(r1_yw);
        d[3] = LEN_W'(r1_xy) + LEN_W'(r1_zw);
        d[4] = LEN_W'(r1_xx) + LEN_W'(r1_zz);
        d[5] = LEN_W'(r1_yz) - LEN_W'(r1_xw);
        d[6] = LEN_W'(r1_xz) - LEN_W'(r1_yw);
        d[7] = LEN_W'(r1_yz) + LEN_W'(r1_xw);
        d[8] = LEN_W'(r1_xx) + LEN_W'(r1_yy);
        for (int l = 0; l < NLANE; l++) begin
            n2_neg[l] = d[l][LEN_W-1];
            n2_mag[l] = d[l][LEN_W-1] ? MAG_W'(-d[l]) : MAG_W'(d[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_len <= LEN_W'(r1_xx) + LEN_W'(r1_yy) + LEN_W'(r1_zz) + LEN_W'(r1_ww);
            r2_mag <= n2_mag;
            r2_neg <= n2_neg;
            r2_px  <= r1_px;
            r2_py  <= r1_py;
            r2_pz  <= r1_pz;
            // round to nearest: (mag*2^16 + len) / (2*len)
            for (int l = 0; l < NLANE; l++) begin
                r3_num[l] <= {r2_mag[l], 16'b0} + REM_W'(r2_len);
            end
            r3_den          <= {r2_len, 1'b0};
            r3_side.neg     <= r2_neg;
            r3_side.short_q <= (r2_len <= LEN_SQ_MIN);
            r3_side.pos_x   <= r2_px;
            r3_side.pos_y   <= r2_py;
            r3_side.pos_z   <= r2_pz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pose.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    qpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_vld   (div_vld),
        .o_quot  (div_quot),
        .o_side  (div_side)
    );

    always_comb begin
        logic signed [V_W-1:0] q;
        logic signed [V_W-1:0] v;
        for (int l = 0; l < NLANE; l++) begin
            q = signed'({1'b0, div_quot[l]});
            if (l == 0 || l == 4 || l == 8) begin
                v = ONE_V - q;
            end else begin
                v = div_side.neg[l] ? -q : q;
            end
            if (v > ONE_V) begin
                v = ONE_V;
            end else if (v < -ONE_V) begin
                v = -ONE_V;
            end
            if (div_side.short_q) begin
                n_m[l] = (l == 0 || l == 4 || l == 8) ? ONE_Q14 : 16'sd0;
            end else begin
                n_m[l] = 16'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
        if (en) begin
            r_out.m00 <= n_m[0];
            r_out.m01 <= n_m[1];
            r_out.m02 <= n_m[2];
            r_out.m10 <= n_m[3];
            r_out.m11 <= n_m[4];
            r_out.m12 <= n_m[5];
            r_out.m20 <= n_m[6];
            r_out.m21 <= n_m[7];
            r_out.m22 <= n_m[8];
            r_out.tx  <= div_side.pos_x;
            r_out.ty  <= div_side.pos_y;
            r_out.tz  <= div_side.pos_z;
        end
    end

    assign o_xform.valid = r_out_vld;
    assign o_xform.data  = r_out;

`ifndef SYNTHESIS
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.m00 <= ONE_Q14 && r_out.m00 >= -ONE_Q14
                    && r_out.m11 <= ONE_Q14 && r_out.m11 >= -ONE_Q14
                    && r_out.m22 <= ONE_Q14 && r_out.m22 >= -ONE_Q14))
        else $error("diagonal entry out of range");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(div_vld) && $stable(div_side))
        else $error("divider advanced while stalled");
`endif

endmodule
